>>> hdl/ftpc_pkg.sv
// ----------------------------------------------------------------------------
// ftpc_pkg
// Shared constants, record codes and the byte-wide CRC-32 step for the framed
// TLV packet checker.
// ----------------------------------------------------------------------------
package ftpc_pkg;

  // Frame layout
  localparam logic [7:0]  MAGIC0      = 8'hA5;
  localparam logic [7:0]  MAGIC1      = 8'h5A;
  localparam logic [7:0]  VERSION_ONE = 8'h01;
  localparam logic [16:0] HDR_LEN     = 17'd14;
  localparam logic [16:0] FRAME_MIN   = 17'd18;
  localparam logic [16:0] POS_MAX     = 17'h1FFFF;

  // CRC-32, reflected
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;

  // Register reset values
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd16384;
  localparam logic [15:0] MAX_VALUE_RST   = 16'd4096;
  localparam logic [7:0]  MAX_FIELDS_RST  = 8'd128;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
  localparam logic [1:0] REG_MAX_VALUE   = 2'd1;
  localparam logic [1:0] REG_MAX_FIELDS  = 2'd2;

  // Record kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // Frame status codes
  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_SHORT        = 4'd1;
  localparam logic [3:0] ST_MAGIC        = 4'd2;
  localparam logic [3:0] ST_VERSION      = 4'd3;
  localparam logic [3:0] ST_PAYLOAD_LONG = 4'd4;
  localparam logic [3:0] ST_MISMATCH     = 4'd5;
  localparam logic [3:0] ST_CRC          = 4'd6;
  localparam logic [3:0] ST_FIELDS       = 4'd7;
  localparam logic [3:0] ST_TRUNC        = 4'd8;
  localparam logic [3:0] ST_VALUE_LONG   = 4'd9;
  localparam logic [3:0] ST_OVERRUN      = 4'd10;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

>>> hdl/framed_tlv_packet_checker.sv
// ----------------------------------------------------------------------------
// framed_tlv_packet_checker
// Checks a framed TLV packet byte by byte: magic, version, payload length,
// frame length and CRC-32, and streams out TLV header and value records and a
// closing status record per frame.
// ----------------------------------------------------------------------------
//
//  port group   role              transfer contents
//  s_*          frame bytes in    tdata: data_byte; tlast: end_of_frame
//  m_*          records out       tuser: record_kind; tlast: value_last;
//                                 tdata: record fields, see the port list
//  p*           register access   max_payload_len, max_value_len, max_field_count
//
//  One byte is taken per cycle while s_tready is high; the parser and the CRC
//  step sit between the frame state and a single output register, so a byte's
//  record appears on m_* in the cycle after its transfer.
//  s_tready is high while the output register is empty or is being emptied.
//  A stall on m_* holds the record and stops input until it is taken.
//  Reset clears the frame state and loads the register reset values.
//  After each end-of-frame byte the frame state returns to its reset value.
// ----------------------------------------------------------------------------
module framed_tlv_packet_checker (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tlast,
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // [7:0] tlv_type, [23:8] value_length,
                                  // [31:24] value_data, [39:32] field_index,
                                  // [43:40] status, [51:44] frame_flags,
                                  // [83:52] sequence_number, [115:84] timestamp,
                                  // [123:116] field_total, [131:124] header_version
  output logic [1:0]   m_tuser,   // [1:0] record_kind
  output logic         m_tlast,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  typedef enum logic [1:0] {PH_TYPE, PH_LEN_HI, PH_LEN_LO, PH_VALUE} phase_t;

  // Configuration registers
  logic [15:0] max_payload_len;
  logic [15:0] max_value_len;
  logic [7:0]  max_field_count;

  // Frame state
  logic [16:0] byte_position, byte_position_next;
  logic [3:0]  first_error, first_error_next;
  logic [7:0]  version_reg, version_reg_next;
  logic [7:0]  flags_reg, flags_reg_next;
  logic [15:0] payload_length_reg, payload_length_reg_next;
  logic [31:0] sequence_reg, sequence_reg_next;
  logic [31:0] time_reg, time_reg_next;
  logic [31:0] crc_accumulator, crc_accumulator_next;
  logic [31:0] tail_bytes, tail_bytes_next;
  phase_t      tlv_phase, tlv_phase_next;
  logic [7:0]  tlv_type_reg, tlv_type_reg_next;
  logic [15:0] tlv_length_reg, tlv_length_reg_next;
  logic [15:0] payload_remaining, payload_remaining_next;
  logic [7:0]  fields_seen, fields_seen_next;
  logic [15:0] value_remaining, value_remaining_next;

  // Output register
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [7:0]  out_type;
  logic [15:0] out_length;
  logic [7:0]  out_data;
  logic [7:0]  out_index;
  logic        out_last;
  logic [3:0]  out_status;
  logic [7:0]  out_flags;
  logic [31:0] out_sequence;
  logic [31:0] out_time;
  logic [7:0]  out_total;
  logic [7:0]  out_version;

  // Per-byte results
  logic        s_fire;
  logic        cfg_write;
  logic [3:0]  err_code;
  logic        rec_valid;
  logic [1:0]  rec_kind;
  logic [7:0]  rec_data;
  logic        rec_last;
  logic [3:0]  frame_status;
  logic [15:0] rem;
  logic [15:0] len_new;
  logic [15:0] vrem;

  assign s_fire    = s_tvalid && s_tready;
  assign s_tready  = !out_valid || m_tready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = 32'd0;
    case (paddr[3:2])
      ftpc_pkg::REG_MAX_PAYLOAD: prdata = {16'd0, max_payload_len};
      ftpc_pkg::REG_MAX_VALUE:   prdata = {16'd0, max_value_len};
      ftpc_pkg::REG_MAX_FIELDS:  prdata = {24'd0, max_field_count};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= ftpc_pkg::MAX_PAYLOAD_RST;
      max_value_len   <= ftpc_pkg::MAX_VALUE_RST;
      max_field_count <= ftpc_pkg::MAX_FIELDS_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        ftpc_pkg::REG_MAX_PAYLOAD: max_payload_len <= pwdata[15:0];
        ftpc_pkg::REG_MAX_VALUE:   max_value_len   <= pwdata[15:0];
        ftpc_pkg::REG_MAX_FIELDS:  max_field_count <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Next frame state for the byte on s_tdata
  always_comb begin
    byte_position_next      = byte_position;
    version_reg_next        = version_reg;
    flags_reg_next          = flags_reg;
    payload_length_reg_next = payload_length_reg;
    sequence_reg_next       = sequence_reg;
    time_reg_next           = time_reg;
    crc_accumulator_next    = crc_accumulator;
    tail_bytes_next         = tail_bytes;
    tlv_phase_next          = tlv_phase;
    tlv_type_reg_next       = tlv_type_reg;
    tlv_length_reg_next     = tlv_length_reg;
    payload_remaining_next  = payload_remaining;
    fields_seen_next        = fields_seen;
    value_remaining_next    = value_remaining;
    err_code  = ftpc_pkg::ST_OK;
    rec_valid = 1'b0;
    rec_kind  = ftpc_pkg::KIND_HEADER;
    rec_data  = 8'd0;
    rec_last  = 1'b0;
    rem       = payload_remaining - 16'd1;
    len_new   = {tlv_length_reg[15:8], s_tdata};
    vrem      = value_remaining - 16'd1;

    if (byte_position != ftpc_pkg::POS_MAX) begin
      byte_position_next = byte_position + 17'd1;
    end

    if (byte_position == 17'd0) begin
      if (s_tdata != ftpc_pkg::MAGIC0) err_code = ftpc_pkg::ST_MAGIC;
    end else if (byte_position == 17'd1) begin
      if (s_tdata != ftpc_pkg::MAGIC1) err_code = ftpc_pkg::ST_MAGIC;
    end else if (byte_position == 17'd2) begin
      version_reg_next = s_tdata;
      if (s_tdata != ftpc_pkg::VERSION_ONE) err_code = ftpc_pkg::ST_VERSION;
    end else if (byte_position == 17'd3) begin
      flags_reg_next = s_tdata;
    end else if (byte_position == 17'd4) begin
      payload_length_reg_next = {s_tdata, 8'd0};
    end else if (byte_position == 17'd5) begin
      payload_length_reg_next = {payload_length_reg[15:8], s_tdata};
      payload_remaining_next  = {payload_length_reg[15:8], s_tdata};
      if ({payload_length_reg[15:8], s_tdata} > max_payload_len) begin
        err_code = ftpc_pkg::ST_PAYLOAD_LONG;
      end
    end else if (byte_position < 17'd10) begin
      sequence_reg_next = {sequence_reg[23:0], s_tdata};
    end else if (byte_position < ftpc_pkg::HDR_LEN) begin
      time_reg_next = {time_reg[23:0], s_tdata};
    end else if (payload_remaining != 16'd0 && first_error == ftpc_pkg::ST_OK) begin
      payload_remaining_next = rem;
      case (tlv_phase)
        PH_TYPE: begin
          if (fields_seen >= max_field_count) begin
            err_code = ftpc_pkg::ST_FIELDS;
          end else begin
            tlv_type_reg_next = s_tdata;
            tlv_phase_next    = PH_LEN_HI;
            if (rem == 16'd0) err_code = ftpc_pkg::ST_TRUNC;
          end
        end
        PH_LEN_HI: begin
          tlv_length_reg_next = {s_tdata, 8'd0};
          tlv_phase_next      = PH_LEN_LO;
          if (rem == 16'd0) err_code = ftpc_pkg::ST_TRUNC;
        end
        PH_LEN_LO: begin
          tlv_length_reg_next = len_new;
          if (len_new > max_value_len) begin
            err_code = ftpc_pkg::ST_VALUE_LONG;
          end else if (len_new > rem) begin
            err_code = ftpc_pkg::ST_OVERRUN;
          end else begin
            rec_valid = 1'b1;
            rec_kind  = ftpc_pkg::KIND_HEADER;
            if (len_new == 16'd0) begin
              // An empty value closes the field on its header record.
              fields_seen_next = fields_seen + 8'd1;
              tlv_phase_next   = PH_TYPE;
            end else begin
              value_remaining_next = len_new;
              tlv_phase_next       = PH_VALUE;
            end
          end
        end
        PH_VALUE: begin
          value_remaining_next = vrem;
          rec_valid = 1'b1;
          rec_kind  = ftpc_pkg::KIND_VALUE;
          rec_data  = s_tdata;
          rec_last  = (vrem == 16'd0);
          if (vrem == 16'd0) begin
            fields_seen_next = fields_seen + 8'd1;
            tlv_phase_next   = PH_TYPE;
          end
        end
        default: ;
      endcase
    end

    // The CRC trails the stream by four bytes so the check word is never hashed.
    if (byte_position >= 17'd2) begin
      if (byte_position >= 17'd6) begin
        crc_accumulator_next = ftpc_pkg::crc32_byte(crc_accumulator, tail_bytes[31:24]);
      end
      tail_bytes_next = {tail_bytes[23:0], s_tdata};
    end

    first_error_next = (first_error != ftpc_pkg::ST_OK) ? first_error : err_code;

    if (byte_position_next < ftpc_pkg::FRAME_MIN) begin
      frame_status = ftpc_pkg::ST_SHORT;
    end else if (first_error_next == ftpc_pkg::ST_MAGIC ||
                 first_error_next == ftpc_pkg::ST_VERSION ||
                 first_error_next == ftpc_pkg::ST_PAYLOAD_LONG) begin
      frame_status = first_error_next;
    end else if (byte_position_next != ftpc_pkg::FRAME_MIN + {1'b0, payload_length_reg_next}) begin
      frame_status = ftpc_pkg::ST_MISMATCH;
    end else if ((crc_accumulator_next ^ ftpc_pkg::CRC_INIT) != tail_bytes_next) begin
      frame_status = ftpc_pkg::ST_CRC;
    end else begin
      frame_status = first_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s_fire && s_tlast)) begin
      byte_position      <= 17'd0;
      first_error        <= ftpc_pkg::ST_OK;
      version_reg        <= 8'd0;
      flags_reg          <= 8'd0;
      payload_length_reg <= 16'd0;
      sequence_reg       <= 32'd0;
      time_reg           <= 32'd0;
      crc_accumulator    <= ftpc_pkg::CRC_INIT;
      tail_bytes         <= 32'd0;
      tlv_phase          <= PH_TYPE;
      tlv_type_reg       <= 8'd0;
      tlv_length_reg     <= 16'd0;
      payload_remaining  <= 16'd0;
      fields_seen        <= 8'd0;
      value_remaining    <= 16'd0;
    end else if (s_fire) begin
      byte_position      <= byte_position_next;
      first_error        <= first_error_next;
      version_reg        <= version_reg_next;
      flags_reg          <= flags_reg_next;
      payload_length_reg <= payload_length_reg_next;
      sequence_reg       <= sequence_reg_next;
      time_reg           <= time_reg_next;
      crc_accumulator    <= crc_accumulator_next;
      tail_bytes         <= tail_bytes_next;
      tlv_phase          <= tlv_phase_next;
      tlv_type_reg       <= tlv_type_reg_next;
      tlv_length_reg     <= tlv_length_reg_next;
      payload_remaining  <= payload_remaining_next;
      fields_seen        <= fields_seen_next;
      value_remaining    <= value_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_fire) begin
      out_valid <= rec_valid || s_tlast;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // The end byte replaces any TLV record it would have caused.
  always_ff @(posedge clk) begin
    if (s_fire && (rec_valid || s_tlast)) begin
      out_flags    <= flags_reg_next;
      out_sequence <= sequence_reg_next;
      out_time     <= time_reg_next;
      out_version  <= version_reg_next;
      if (s_tlast) begin
        out_kind   <= ftpc_pkg::KIND_END;
        out_type   <= 8'd0;
        out_length <= 16'd0;
        out_data   <= 8'd0;
        out_index  <= 8'd0;
        out_last   <= 1'b0;
        out_status <= frame_status;
        out_total  <= fields_seen_next;
      end else begin
        out_kind   <= rec_kind;
        out_type   <= tlv_type_reg_next;
        out_length <= tlv_length_reg_next;
        out_data   <= rec_data;
        out_index  <= fields_seen;
        out_last   <= rec_last;
        out_status <= ftpc_pkg::ST_OK;
        out_total  <= fields_seen;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {4'd0, out_version, out_total, out_time, out_sequence, out_flags,
                     out_status, out_index, out_data, out_length, out_type};

  // Checks
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_tlast |=> byte_position == 17'd0 && first_error == ftpc_pkg::ST_OK)
    else $error("frame state not cleared after end byte");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ftpc_pkg::KIND_END |-> m_tdata[43:40] == ftpc_pkg::ST_OK)
    else $error("nonzero status on a TLV record");

  a_last_on_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == ftpc_pkg::KIND_VALUE)
    else $error("value_last on a record that is not a value byte");

  a_quiet_after_error: assert property (@(posedge clk) disable iff (rst)
    s_fire && first_error != ftpc_pkg::ST_OK && !s_tlast |=> !m_tvalid)
    else $error("record emitted after an error was latched");

  a_value_count: assert property (@(posedge clk) disable iff (rst)
    tlv_phase == PH_VALUE |-> value_remaining != 16'd0)
    else $error("value phase with no bytes left");

endmodule

>>> tb/sv/ftpc_record_checker.sv
// ----------------------------------------------------------------------------
// ftpc_record_checker
// Watches the byte and record channels and the register port of the framed TLV
// packet checker. It follows each accepted frame byte with its own copy of the
// frame and TLV state, queues the records that byte must produce, and compares
// every record transfer, field by field, with the oldest record still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftpc_record_checker
  import ftpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [7:0]   s_tdata,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [135:0] m_tdata,
  input  logic [1:0]   m_tuser,
  input  logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           mismatch_count,
  output int           records_due
);

  typedef enum logic [1:0] {WANT_TYPE, WANT_LEN_HI, WANT_LEN_LO, WANT_VALUE} tlv_step_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ttype;
    logic [15:0] vlen;
    logic [7:0]  vdata;
    logic [7:0]  index;
    logic        vlast;
    logic [3:0]  status;
    logic [7:0]  flags;
    logic [31:0] seq;
    logic [31:0] stamp;
    logic [7:0]  total;
    logic [7:0]  version;
  } record_t;

  logic [15:0] lim_payload, lim_value;
  logic [7:0]  lim_fields;

  logic [16:0] byte_count;
  logic [3:0]  first_err;
  logic [7:0]  version_seen, flags_seen;
  logic [15:0] hdr_plen, payload_left, field_len, value_left;
  logic [31:0] seq_seen, time_seen, crc_run, last_four;
  tlv_step_t   tlv_step;
  logic [7:0]  field_type, fields_done;

  record_t expected_records[$];
  int      mismatches;

  // Reflected CRC-32, one data bit per step, least significant bit first.
  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] octet);
    logic [31:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ octet[i]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic record_t make_record(input logic [1:0] kind, input logic [7:0] data,
                                          input logic last, input logic [3:0] st);
    record_t r;
    r.kind    = kind;
    r.ttype   = (kind == KIND_END) ? 8'd0 : field_type;
    r.vlen    = (kind == KIND_END) ? 16'd0 : field_len;
    r.vdata   = data;
    r.index   = (kind == KIND_END) ? 8'd0 : fields_done;
    r.vlast   = last;
    r.status  = st;
    r.flags   = flags_seen;
    r.seq     = seq_seen;
    r.stamp   = time_seen;
    r.total   = fields_done;
    r.version = version_seen;
    return r;
  endfunction

  function automatic string record_text(input record_t r);
    return $sformatf("kind %0d type %02h len %0d data %02h idx %0d last %0b st %0d %s",
                     r.kind, r.ttype, r.vlen, r.vdata, r.index, r.vlast, r.status,
                     $sformatf("flags %02h seq %08h time %08h total %0d ver %02h",
                               r.flags, r.seq, r.stamp, r.total, r.version));
  endfunction

  task automatic clear_frame();
    byte_count   = '0;
    first_err    = ST_OK;
    version_seen = '0;
    flags_seen   = '0;
    hdr_plen     = '0;
    payload_left = '0;
    field_len    = '0;
    value_left   = '0;
    seq_seen     = '0;
    time_seen    = '0;
    crc_run      = CRC_INIT;
    last_four    = '0;
    tlv_step     = WANT_TYPE;
    field_type   = '0;
    fields_done  = '0;
  endtask

  // Only the first error of a frame is kept.
  task automatic note_error(input logic [3:0] code);
    if (first_err == ST_OK) first_err = code;
  endtask

  task automatic parse_payload(input logic [7:0] b, output logic have, output record_t rec);
    have = 1'b0;
    rec = '0;
    payload_left = payload_left - 16'd1;
    case (tlv_step)
      WANT_TYPE: begin
        if (fields_done >= lim_fields) begin
          note_error(ST_FIELDS);
        end else begin
          field_type = b;
          tlv_step = WANT_LEN_HI;
          if (payload_left == 16'd0) note_error(ST_TRUNC);
        end
      end
      WANT_LEN_HI: begin
        field_len = {b, 8'h00};
        tlv_step = WANT_LEN_LO;
        if (payload_left == 16'd0) note_error(ST_TRUNC);
      end
      WANT_LEN_LO: begin
        field_len = {field_len[15:8], b};
        if (field_len > lim_value) begin
          note_error(ST_VALUE_LONG);
        end else if (field_len > payload_left) begin
          note_error(ST_OVERRUN);
        end else begin
          have = 1'b1;
          rec = make_record(KIND_HEADER, 8'd0, 1'b0, ST_OK);
          if (field_len == 16'd0) begin
            fields_done = fields_done + 8'd1;
            tlv_step = WANT_TYPE;
          end else begin
            value_left = field_len;
            tlv_step = WANT_VALUE;
          end
        end
      end
      default: begin
        value_left = value_left - 16'd1;
        have = 1'b1;
        rec = make_record(KIND_VALUE, b, value_left == 16'd0, ST_OK);
        if (value_left == 16'd0) begin
          fields_done = fields_done + 8'd1;
          tlv_step = WANT_TYPE;
        end
      end
    endcase
  endtask

  task automatic take_byte(input logic [7:0] b, input logic eof);
    logic [16:0] at;
    logic [3:0]  st;
    logic        have;
    record_t     rec;
    at = byte_count;
    have = 1'b0;
    rec = '0;
    if (byte_count != POS_MAX) byte_count = byte_count + 17'd1;

    if (at == 17'd0) begin
      if (b != MAGIC0) note_error(ST_MAGIC);
    end else if (at == 17'd1) begin
      if (b != MAGIC1) note_error(ST_MAGIC);
    end else if (at == 17'd2) begin
      version_seen = b;
      if (b != VERSION_ONE) note_error(ST_VERSION);
    end else if (at == 17'd3) begin
      flags_seen = b;
    end else if (at == 17'd4) begin
      hdr_plen = {b, 8'h00};
    end else if (at == 17'd5) begin
      hdr_plen = {hdr_plen[15:8], b};
      payload_left = hdr_plen;
      if (hdr_plen > lim_payload) note_error(ST_PAYLOAD_LONG);
    end else if (at < 17'd10) begin
      seq_seen = {seq_seen[23:0], b};
    end else if (at < HDR_LEN) begin
      time_seen = {time_seen[23:0], b};
    end else if (payload_left != 16'd0 && first_err == ST_OK) begin
      parse_payload(b, have, rec);
    end

    // The CRC runs four bytes behind, so the trailing word never enters it.
    if (at >= 17'd2) begin
      if (at >= 17'd6) crc_run = crc_update(crc_run, last_four[31:24]);
      last_four = {last_four[23:0], b};
    end

    if (eof) begin
      if (byte_count < FRAME_MIN) st = ST_SHORT;
      else if (first_err >= ST_MAGIC && first_err <= ST_PAYLOAD_LONG) st = first_err;
      else if (byte_count != FRAME_MIN + {1'b0, hdr_plen}) st = ST_MISMATCH;
      else if (~crc_run != last_four) st = ST_CRC;
      else st = first_err;
      expected_records.insert(expected_records.size(),
                              make_record(KIND_END, 8'd0, 1'b0, st));
      clear_frame();
    end else if (have) begin
      expected_records.insert(expected_records.size(), rec);
    end
  endtask

  always @(posedge clk) begin
    record_t seen, want;
    if (rst) begin
      lim_payload = MAX_PAYLOAD_RST;
      lim_value = MAX_VALUE_RST;
      lim_fields = MAX_FIELDS_RST;
      clear_frame();
      expected_records.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MAX_PAYLOAD: lim_payload = pwdata[15:0];
          REG_MAX_VALUE:   lim_value = pwdata[15:0];
          REG_MAX_FIELDS:  lim_fields = pwdata[7:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        seen.kind    = m_tuser;
        seen.ttype   = m_tdata[7:0];
        seen.vlen    = m_tdata[23:8];
        seen.vdata   = m_tdata[31:24];
        seen.index   = m_tdata[39:32];
        seen.vlast   = m_tlast;
        seen.status  = m_tdata[43:40];
        seen.flags   = m_tdata[51:44];
        seen.seq     = m_tdata[83:52];
        seen.stamp   = m_tdata[115:84];
        seen.total   = m_tdata[123:116];
        seen.version = m_tdata[131:124];
        if (expected_records.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: record transfer with none due: %s", $time, record_text(seen));
          end
          mismatches++;
        end else begin
          want = expected_records.pop_front();
          if (seen != want) begin
            if (mismatches < 10) begin
              $display("%0t: record mismatch", $time);
              $display("  expected %s", record_text(want));
              $display("  actual   %s", record_text(seen));
            end
            mismatches++;
          end
        end
      end

      if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
    end
    mismatch_count <= mismatches;
    records_due <= expected_records.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Feeds framed TLV packets into the packet checker: a directed set of clean and
// broken frames, then random frames under several register settings and
// several patterns of sender gaps and receiver stalls. Record checking is done
// by the record checker beside the block; this module only drives and judges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ftpc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int mismatch_count;
  int records_due;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int bytes_sent = 0;

  logic [15:0] cur_max_payload = MAX_PAYLOAD_RST;
  logic [15:0] cur_max_value = MAX_VALUE_RST;

  logic [7:0] payload_buf[$];
  logic [7:0] frame_buf[$];

  framed_tlv_packet_checker i_dut (.*);

  ftpc_record_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic add_field(input logic [7:0] ftype, input logic [15:0] len);
    payload_buf.insert(payload_buf.size(), ftype);
    payload_buf.insert(payload_buf.size(), len[15:8]);
    payload_buf.insert(payload_buf.size(), len[7:0]);
    repeat (len) payload_buf.insert(payload_buf.size(), 8'($urandom));
  endtask

  // Builds header, payload and trailing CRC into frame_buf.
  task automatic assemble(input logic [7:0] ver, input logic [7:0] flags,
                          input logic [31:0] seq, input logic [31:0] stamp,
                          input logic [15:0] plen);
    logic [31:0] crc;
    frame_buf.delete();
    frame_buf.insert(frame_buf.size(), MAGIC0);
    frame_buf.insert(frame_buf.size(), MAGIC1);
    frame_buf.insert(frame_buf.size(), ver);
    frame_buf.insert(frame_buf.size(), flags);
    frame_buf.insert(frame_buf.size(), plen[15:8]);
    frame_buf.insert(frame_buf.size(), plen[7:0]);
    for (int i = 3; i >= 0; i--) frame_buf.insert(frame_buf.size(), seq[8*i +: 8]);
    for (int i = 3; i >= 0; i--) frame_buf.insert(frame_buf.size(), stamp[8*i +: 8]);
    foreach (payload_buf[i]) frame_buf.insert(frame_buf.size(), payload_buf[i]);
    crc = CRC_INIT;
    for (int i = 2; i < frame_buf.size(); i++) begin
      crc = crc ^ {24'd0, frame_buf[i]};
      repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    crc = ~crc;
    for (int i = 3; i >= 0; i--) frame_buf.insert(frame_buf.size(), crc[8*i +: 8]);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      while ($urandom_range(99) < idle_pct) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= frame_buf[i];
      s_tlast <= (i == frame_buf.size() - 1);
      do @(posedge clk); while (!s_tready);
      bytes_sent++;
    end
  endtask

  // Holds the sender off until every due record has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (records_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [15:0] pay_limit, input logic [15:0] value_limit,
                             input logic [7:0] field_limit, input int idle, input int stall);
    drain();
    apb_write(REG_MAX_PAYLOAD, {16'd0, pay_limit});
    apb_write(REG_MAX_VALUE, {16'd0, value_limit});
    apb_write(REG_MAX_FIELDS, {24'd0, field_limit});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_max_payload = pay_limit;
    cur_max_value = value_limit;
    idle_pct = idle;
    stall_pct = stall;
  endtask

  task automatic random_frame();
    int          mode;
    int          rem;
    logic [15:0] len;
    logic [15:0] plen;
    logic [7:0]  ver;
    mode = $urandom_range(99);
    payload_buf.delete();
    if (mode >= 96) begin
      frame_buf.delete();
      repeat ($urandom_range(1, 40)) frame_buf.insert(frame_buf.size(), 8'($urandom));
    end else if (mode >= 92) begin
      // Too short to hold a header and a CRC.
      frame_buf.delete();
      frame_buf.insert(frame_buf.size(), MAGIC0);
      repeat ($urandom_range(0, 16)) frame_buf.insert(frame_buf.size(), 8'($urandom));
    end else begin
      repeat ($urandom_range(0, 5)) begin
        len = ($urandom_range(9) < 8) ? 16'($urandom_range(0, 4)) : 16'($urandom_range(0, 16));
        add_field(8'($urandom), len);
      end
      if (mode >= 60 && mode < 64) begin
        // Payload ends inside a TLV header.
        payload_buf.insert(payload_buf.size(), 8'($urandom));
        if ($urandom_range(1)) payload_buf.insert(payload_buf.size(), 8'($urandom));
      end else if (mode >= 64 && mode < 68) begin
        len = (cur_max_value > 16'hFFFC) ? 16'hFFFF
                                         : cur_max_value + 16'($urandom_range(1, 3));
        payload_buf.insert(payload_buf.size(), 8'($urandom));
        payload_buf.insert(payload_buf.size(), len[15:8]);
        payload_buf.insert(payload_buf.size(), len[7:0]);
      end else if (mode >= 68 && mode < 72) begin
        // Declared value runs past the end of the payload.
        rem = $urandom_range(0, 3);
        len = 16'(rem + $urandom_range(1, 3));
        payload_buf.insert(payload_buf.size(), 8'($urandom));
        payload_buf.insert(payload_buf.size(), len[15:8]);
        payload_buf.insert(payload_buf.size(), len[7:0]);
        repeat (rem) payload_buf.insert(payload_buf.size(), 8'($urandom));
      end
      ver = VERSION_ONE;
      if (mode >= 72 && mode < 76) begin
        ver = 8'($urandom);
        if (ver == VERSION_ONE) ver = 8'h00;
      end
      plen = 16'(payload_buf.size());
      if (mode >= 76 && mode < 80 && cur_max_payload < 16'hFFF0) begin
        plen = cur_max_payload + 16'($urandom_range(1, 8));
      end
      assemble(ver, 8'($urandom), $urandom, $urandom, plen);
      if (mode >= 80 && mode < 84) begin
        frame_buf[$urandom_range(1)] ^= 8'(1 << $urandom_range(7));
      end else if (mode >= 84 && mode < 88) begin
        frame_buf[frame_buf.size() - 1 - $urandom_range(3)] ^= 8'(1 << $urandom_range(7));
      end else if (mode >= 88) begin
        if ($urandom_range(1)) frame_buf.insert(frame_buf.size(), 8'($urandom));
        else frame_buf.delete($urandom_range(2, frame_buf.size() - 2));
      end
    end
    send_frame();
  endtask

  task automatic random_burst(input int quota);
    int stop_at;
    stop_at = bytes_sent + quota;
    while (bytes_sent < stop_at) random_frame();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Clean frames with header fields at their extremes and a zero-length field.
    payload_buf.delete();
    add_field(8'h00, 16'd0);
    add_field(8'hFF, 16'd3);
    add_field(8'h5A, 16'd1);
    assemble(VERSION_ONE, 8'hFF, 32'hFFFF_FFFF, 32'h0, 16'(payload_buf.size()));
    send_frame();
    payload_buf.delete();
    assemble(VERSION_ONE, 8'h00, 32'h0, 32'hFFFF_FFFF, 16'd0);
    send_frame();

    // Bad magic in either byte, then bad versions; no records may leak out.
    add_field(8'h11, 16'd2);
    assemble(VERSION_ONE, 8'h01, 32'h1, 32'h2, 16'(payload_buf.size()));
    frame_buf[0] = 8'hA4;
    send_frame();
    frame_buf[0] = MAGIC0;
    frame_buf[1] = 8'hDA;
    send_frame();
    assemble(8'h00, 8'h02, 32'h3, 32'h4, 16'(payload_buf.size()));
    send_frame();
    assemble(8'hFF, 8'h03, 32'h5, 32'h6, 16'(payload_buf.size()));
    send_frame();

    // Header length one above the reset limit.
    payload_buf.delete();
    assemble(VERSION_ONE, 8'h3C, $urandom, $urandom, MAX_PAYLOAD_RST + 16'd1);
    send_frame();

    // One byte too many, and a frame that ends on a value byte.
    add_field(8'h21, 16'd4);
    assemble(VERSION_ONE, 8'h44, $urandom, $urandom, 16'(payload_buf.size()));
    frame_buf.insert(frame_buf.size(), 8'h00);
    send_frame();
    payload_buf.delete();
    add_field(8'h22, 16'd10);
    assemble(VERSION_ONE, 8'h45, $urandom, $urandom, 16'(payload_buf.size()));
    while (frame_buf.size() > 22) void'(frame_buf.pop_back());
    send_frame();

    // Corrupted CRC word.
    assemble(VERSION_ONE, 8'h46, $urandom, $urandom, 16'(payload_buf.size()));
    frame_buf[frame_buf.size() - 1] ^= 8'h80;
    send_frame();

    // Short frames: a lone byte, and one byte under the minimum.
    frame_buf = {MAGIC0};
    send_frame();
    payload_buf.delete();
    assemble(VERSION_ONE, 8'h47, $urandom, $urandom, 16'd0);
    void'(frame_buf.pop_back());
    send_frame();

    // Payload ends after the type byte, then after the first length byte.
    payload_buf = {8'h30};
    assemble(VERSION_ONE, 8'h48, $urandom, $urandom, 16'(payload_buf.size()));
    send_frame();
    payload_buf = {8'h30, 8'h00};
    assemble(VERSION_ONE, 8'h49, $urandom, $urandom, 16'(payload_buf.size()));
    send_frame();

    // Value one above the reset limit, then a value longer than what is left.
    payload_buf = {8'h31, 8'h10, 8'h01};
    assemble(VERSION_ONE, 8'h4A, $urandom, $urandom, 16'(payload_buf.size()));
    send_frame();
    payload_buf = {8'h32, 8'h00, 8'h05, 8'hAA, 8'h55};
    assemble(VERSION_ONE, 8'h4B, $urandom, $urandom, 16'(payload_buf.size()));
    send_frame();

    // A version error outranks a CRC error.
    payload_buf.delete();
    assemble(8'h02, 8'h4C, $urandom, $urandom, 16'd0);
    frame_buf[frame_buf.size() - 1] ^= 8'h01;
    send_frame();

    // Limits at their top values.
    reconfigure(16'hFFFF, 16'hFFFF, 8'hFF, 0, 0);
    assemble(VERSION_ONE, 8'h50, $urandom, $urandom, 16'hFFFF);
    send_frame();
    payload_buf = {8'h40, 8'hFF, 8'hFF};
    assemble(VERSION_ONE, 8'h51, $urandom, $urandom, 16'(payload_buf.size()));
    send_frame();
    random_burst(275);

    reconfigure(16'd40, 16'd6, 8'd4, 58, 0);
    random_burst(325);
    reconfigure(16'd0, 16'd0, 8'd0, 0, 58);
    random_burst(175);
    reconfigure(16'd64, 16'd12, 8'd255, 28, 28);
    random_burst(150);
    drain();
    random_burst(150);
    reconfigure(MAX_PAYLOAD_RST, MAX_VALUE_RST, MAX_FIELDS_RST, 0, 0);
    random_burst(225);

    drain();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
